### src/modexp_pkg.sv
package modexp_pkg;
    localparam int unsigned WIDTH_DEFAULT = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned FIELD_W = 32;
    localparam logic CFG_IDX_EXPONENT = 1'b0;
    localparam logic CFG_IDX_MODULUS = 1'b1;

    // state codes of the top-level sequencer
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED = 3'd1;
    localparam logic [2:0] ST_SQR = 3'd2;
    localparam logic [2:0] ST_MUL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    typedef struct packed {
        logic start;
    } mm_ctrl_t;
endpackage

### src/modexp_cell.sv
// one bit slice of the modular adder chain: sum and compare ripple through cells
module modexp_cell (
    input  logic a_bit,
    input  logic b_bit,
    input  logic gap_bit,
    input  logic carry_in,
    input  logic borrow_in,
    output logic sum_bit,
    output logic carry_out,
    output logic diff_bit,
    output logic borrow_out
);
    assign sum_bit = a_bit ^ b_bit ^ carry_in;
    assign carry_out = (a_bit & b_bit) | (carry_in & (a_bit ^ b_bit));
    assign diff_bit = a_bit ^ gap_bit ^ borrow_in;
    assign borrow_out = (~a_bit & gap_bit) | (borrow_in & ~(a_bit ^ gap_bit));
endmodule

### src/modexp_mulmod.sv
// shift-and-add modular multiplier: each multiplier bit takes a doubling phase, then an add phase
module modexp_mulmod #(
    parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  modexp_pkg::mm_ctrl_t  ctrl,
    input  logic [WIDTH-1:0]      op_a,
    input  logic [WIDTH-1:0]      op_b,
    input  logic [WIDTH-1:0]      modulus,
    output logic [WIDTH-1:0]      product,
    output logic                  done
);
    localparam int unsigned CW = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    logic [WIDTH-1:0] add_in, gap, sum, diff, addmod;
    logic [WIDTH:0]   carry, borrow;

    // phase 0 doubles acc, phase 1 adds op_a when the bit is set
    assign add_in = phase_reg ? op_a : acc_reg;
    assign gap = modulus - add_in;
    assign carry[0] = 1'b0;
    assign borrow[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < WIDTH; i++) begin : g_cell
            modexp_cell u_cell (
                .a_bit     (acc_reg[i]),
                .b_bit     (add_in[i]),
                .gap_bit   (gap[i]),
                .carry_in  (carry[i]),
                .borrow_in (borrow[i]),
                .sum_bit   (sum[i]),
                .carry_out (carry[i+1]),
                .diff_bit  (diff[i]),
                .borrow_out(borrow[i+1])
            );
        end
    endgenerate

    // no borrow means acc >= gap, so wrap by subtracting the gap
    assign addmod = borrow[WIDTH] ? sum : diff;

    always_comb begin
        acc_next = acc_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            acc_next = '0;
            b_next = op_b;
            cnt_next = CW'(WIDTH - 1);
            phase_next = 1'b0;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!phase_reg) begin
                acc_next = addmod;
                phase_next = 1'b1;
            end else begin
                if (b_reg[WIDTH-1]) begin
                    acc_next = addmod;
                end
                b_next = {b_reg[WIDTH-2:0], 1'b0};
                phase_next = 1'b0;
                if (cnt_reg == '0) begin
                    run_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            done_reg <= done_next;
            phase_reg <= phase_next;
        end
        acc_reg <= acc_next;
        b_reg <= b_next;
        cnt_reg <= cnt_next;
    end

    assign product = acc_reg;
    assign done = done_reg;
endmodule

### src/modular_exponentiation.sv
// modular exponentiation: power_result = base ^ exponent mod modulus
// channels:
//   s_axis_*  : one base per transaction (tdata = base)
//   m_axis_*  : one power_result per transaction (tdata = power_result)
//   cfg_*     : register writes, index 0 exponent, index 1 modulus
// sequence per item, from acceptance to the result appearing:
//   reduction of base by restoring subtract steps
//   then WIDTH exponent bits, each one squaring plus, when the bit is set, one
//   multiply, every modular multiply running in the shared bit-slice chain
// one item at a time: s_axis_tready is high only while the block is idle,
// and the next base can be taken at the earliest in the cycle after the result leaves
// the result sits in the output register until m_axis_tready; a stalled
// receiver simply holds the block in its done state
// reset (aresetn low, synchronous) gives exponent 1, modulus 2, no item
// modulus 0 returns 0
module modular_exponentiation #(
    parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [modexp_pkg::FIELD_W-1:0] s_axis_tdata,  // [31:0] base
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [modexp_pkg::FIELD_W-1:0] m_axis_tdata,  // [31:0] power_result
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [modexp_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] exp_reg, mod_reg;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] ebits_reg, ebits_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             go_reg, go_next;
    logic [WIDTH-1:0] res_reg, res_next;

    logic [WIDTH-1:0] mm_a, mm_b, mm_p;
    logic             mm_done;
    modexp_pkg::mm_ctrl_t mm_ctrl;
    logic [WIDTH:0]   rem_sh;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == modexp_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == modexp_pkg::ST_DONE);
    assign m_axis_tdata = modexp_pkg::FIELD_W'(res_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= WIDTH'(1);
            mod_reg <= WIDTH'(2);
        end else if (cfg_valid) begin
            if (cfg_index == modexp_pkg::CFG_IDX_EXPONENT) begin
                exp_reg <= WIDTH'(cfg_data);
            end else begin
                mod_reg <= WIDTH'(cfg_data);
            end
        end
    end

    // restoring division step for base reduction
    assign rem_sh = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};

    assign mm_a = acc_reg;
    assign mm_b = (state_reg == modexp_pkg::ST_MUL) ? base_reg : acc_reg;
    assign mm_ctrl.start = go_reg;

    modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mm_ctrl),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (mod_reg),
        .product (mm_p),
        .done    (mm_done)
    );

    always_comb begin
        state_next = state_reg;
        base_next = base_reg;
        acc_next = acc_reg;
        ebits_next = ebits_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        go_next = 1'b0;
        res_next = res_reg;
        unique case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (mod_reg == '0) begin
                        res_next = '0;
                        state_next = modexp_pkg::ST_DONE;
                    end else begin
                        rem_next = '0;
                        quo_next = WIDTH'(s_axis_tdata);
                        cnt_next = CW'(WIDTH);
                        ebits_next = exp_reg;
                        // 1 mod m: 0 only when m is 1
                        acc_next = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                        state_next = modexp_pkg::ST_RED;
                    end
                end
            end
            modexp_pkg::ST_RED: begin
                if (cnt_reg == '0) begin
                    base_next = rem_reg[WIDTH-1:0];
                    cnt_next = CW'(WIDTH);
                    go_next = 1'b1;
                    state_next = modexp_pkg::ST_SQR;
                end else begin
                    if (rem_sh >= {1'b0, mod_reg}) begin
                        rem_next = rem_sh - {1'b0, mod_reg};
                    end else begin
                        rem_next = rem_sh;
                    end
                    quo_next = {quo_reg[WIDTH-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            modexp_pkg::ST_SQR: begin
                if (mm_done) begin
                    acc_next = mm_p;
                    go_next = 1'b1;
                    if (ebits_reg[WIDTH-1]) begin
                        state_next = modexp_pkg::ST_MUL;
                    end else if (cnt_reg == CW'(1)) begin
                        go_next = 1'b0;
                        res_next = mm_p;
                        state_next = modexp_pkg::ST_DONE;
                    end else begin
                        ebits_next = {ebits_reg[WIDTH-2:0], 1'b0};
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            modexp_pkg::ST_MUL: begin
                if (mm_done) begin
                    acc_next = mm_p;
                    ebits_next = {ebits_reg[WIDTH-2:0], 1'b0};
                    if (cnt_reg == CW'(1)) begin
                        res_next = mm_p;
                        state_next = modexp_pkg::ST_DONE;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                        go_next = 1'b1;
                        state_next = modexp_pkg::ST_SQR;
                    end
                end
            end
            modexp_pkg::ST_DONE: begin
                if (m_axis_tready) begin
                    state_next = modexp_pkg::ST_IDLE;
                end
            end
            default: state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= modexp_pkg::ST_IDLE;
            go_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg <= go_next;
        end
        base_reg <= base_next;
        acc_reg <= acc_next;
        ebits_reg <= ebits_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    // no base is taken while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // a multiply never completes while the sequencer is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == modexp_pkg::ST_IDLE) |-> !mm_done)
        else $error("stray multiply completion");

    // the result is below a nonzero modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && mod_reg != '0) |-> (res_reg < mod_reg))
        else $error("result not reduced");
endmodule
